// ===== rtl/core/tgarle_pkg.sv =====
// Shared types and constants for the run-length coded true-color pixel decoder.
// No dependencies; used by tga_rle_pixel_decoder_unit.
package tgarle_pkg;

  // Default upper bound on image width and height
  localparam int unsigned DefaultMaxDim = 4096;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALPHA_IN_STREAM = 2'd0,
    CFG_IMAGE_WIDTH     = 2'd1,
    CFG_IMAGE_HEIGHT    = 2'd2
  } cfg_idx_e;

  // Register reset values
  localparam logic [CfgW-1:0] WidthReset  = 13'd64;
  localparam logic [CfgW-1:0] HeightReset = 13'd64;

  // Packet header layout
  localparam int unsigned HdrRunBit = 7;

  // Color key (magenta) and the alpha values it selects
  localparam logic [ByteW-1:0] KeyRed     = 8'hff;
  localparam logic [ByteW-1:0] KeyGreen   = 8'h00;
  localparam logic [ByteW-1:0] KeyBlue    = 8'hff;
  localparam logic [ByteW-1:0] AlphaKeyed = 8'h00;
  localparam logic [ByteW-1:0] AlphaOpaque = 8'hff;

endpackage

// ===== rtl/core/tga_rle_pixel_decoder_unit.sv =====
// Top level of the run-length coded true-color pixel decoder.
// Depends on tgarle_pkg for widths, register indexes and key color constants.
//
// The decoder takes one compressed byte per cycle while results are taken and
// returns one result per completed pixel: its colour, its alpha and a repeat
// count (1 to 128), so a run packet yields a single result. Bytes pass through
// an input register and the parser, and a result is written to the output
// register as its last byte leaves the input register; the output register
// lets the next byte be taken while a result waits. Sustained rate is one byte
// per cycle while results are taken. Pixels are counted over the whole image
// (width times height, each clamped to 1..MAX_DIM); a packet that overruns the
// image end is clipped and the result that completes the image carries
// image_done. The image size product sits in a register, so after a
// configuration write the byte input holds off while that product settles.
module tga_rle_pixel_decoder_unit #(
  parameter int unsigned MAX_DIM = tgarle_pkg::DefaultMaxDim
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // compressed byte stream
  input  logic                               data_valid_i,
  output logic                               data_ready_o,
  input  logic [tgarle_pkg::ByteW-1:0]       data_byte_i,
  input  logic                               image_start_i,
  // decoded pixels
  output logic                               pix_valid_o,
  input  logic                               pix_ready_i,
  output logic [tgarle_pkg::ByteW-1:0]       blue_o,
  output logic [tgarle_pkg::ByteW-1:0]       green_o,
  output logic [tgarle_pkg::ByteW-1:0]       red_o,
  output logic [tgarle_pkg::ByteW-1:0]       alpha_o,
  output logic [tgarle_pkg::ByteW-1:0]       repeat_res_o,
  output logic                               image_done_o,
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tgarle_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [tgarle_pkg::CfgW-1:0]        cfg_data_i
);

  localparam int unsigned ByteW   = tgarle_pkg::ByteW;
  localparam int unsigned CfgW    = tgarle_pkg::CfgW;
  // largest dimension a register can express after clamping
  localparam int unsigned CfgMax  = (1 << CfgW) - 1;
  localparam int unsigned DimMax  = (MAX_DIM < CfgMax) ? MAX_DIM : CfgMax;
  localparam int unsigned DimW    = $clog2(DimMax + 1);
  localparam int unsigned TotW    = 2 * DimW;
  localparam int unsigned CmpW    = (TotW > ByteW) ? TotW : ByteW;

  // parser phase
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_BLUE,
    PH_GREEN,
    PH_RED,
    PH_ALPHA
  } phase_e;

  // configuration registers
  logic            alpha_in_stream_q;
  logic [CfgW-1:0] image_width_q, image_height_q;
  logic            cfg_pend_q;
  logic            cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_in_stream_q <= 1'b0;
      image_width_q     <= tgarle_pkg::WidthReset;
      image_height_q    <= tgarle_pkg::HeightReset;
      cfg_pend_q        <= 1'b0;
    end else begin
      cfg_pend_q <= cfg_fire;
      if (cfg_fire) begin
        unique case (cfg_index_i)
          tgarle_pkg::CFG_ALPHA_IN_STREAM: alpha_in_stream_q <= cfg_data_i[0];
          tgarle_pkg::CFG_IMAGE_WIDTH:     image_width_q     <= cfg_data_i;
          tgarle_pkg::CFG_IMAGE_HEIGHT:    image_height_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // clamp dimensions to 1..DimMax and register the pixel count of the image
  logic [DimW-1:0] width_cl, height_cl;
  logic [TotW-1:0] total_q;

  always_comb begin
    if (image_width_q == '0) begin
      width_cl = DimW'(1);
    end else if (image_width_q > CfgW'(DimMax)) begin
      width_cl = DimW'(DimMax);
    end else begin
      width_cl = DimW'(image_width_q);
    end
    if (image_height_q == '0) begin
      height_cl = DimW'(1);
    end else if (image_height_q > CfgW'(DimMax)) begin
      height_cl = DimW'(DimMax);
    end else begin
      height_cl = DimW'(image_height_q);
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= TotW'(width_cl) * TotW'(height_cl);
  end

  // input register
  logic             in_vld_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_start_q;
  logic             out_vld_q;
  logic             out_free;
  logic             fire;
  logic             in_fire;

  assign out_free     = ~out_vld_q | pix_ready_i;
  assign fire         = in_vld_q & out_free;
  assign data_ready_o = ~cfg_pend_q & (~in_vld_q | out_free);
  assign in_fire      = data_valid_i & data_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_byte_q  <= data_byte_i;
      in_start_q <= image_start_i;
    end
  end

  // parser state
  phase_e           phase_q, phase_d;
  logic             run_q, run_d;
  logic [ByteW-1:0] left_q, left_d;
  logic [ByteW-1:0] blue_q, blue_d, green_q, green_d, red_q, red_d;
  logic [TotW-1:0]  done_q, done_d;

  // effective state after an image start
  phase_e           phase_s;
  logic             run_s;
  logic [ByteW-1:0] left_s;
  logic [TotW-1:0]  done_s;

  // emission
  logic             emit;
  logic [ByteW-1:0] alpha_sel;
  logic [CmpW-1:0]  want, remain, total_x, done_x;
  logic [ByteW-1:0] rep;
  logic             fin;
  logic             keyed;

  always_comb begin
    phase_s = in_start_q ? PH_HEADER : phase_q;
    run_s   = in_start_q ? 1'b0 : run_q;
    left_s  = in_start_q ? '0 : left_q;
    done_s  = in_start_q ? '0 : done_q;

    phase_d = phase_s;
    run_d   = run_s;
    left_d  = left_s;
    blue_d  = blue_q;
    green_d = green_q;
    red_d   = red_q;
    done_d  = done_s;
    emit    = 1'b0;

    keyed = (in_byte_q == tgarle_pkg::KeyRed) && (green_q == tgarle_pkg::KeyGreen)
         && (blue_q == tgarle_pkg::KeyBlue);
    alpha_sel = in_byte_q;

    unique case (phase_s)
      PH_BLUE: begin
        blue_d  = in_byte_q;
        phase_d = PH_GREEN;
      end
      PH_GREEN: begin
        green_d = in_byte_q;
        phase_d = PH_RED;
      end
      PH_RED: begin
        red_d = in_byte_q;
        if (alpha_in_stream_q) begin
          phase_d = PH_ALPHA;
        end else begin
          emit      = 1'b1;
          alpha_sel = keyed ? tgarle_pkg::AlphaKeyed : tgarle_pkg::AlphaOpaque;
        end
      end
      PH_ALPHA: begin
        emit = 1'b1;
      end
      default: begin
        run_d   = in_byte_q[tgarle_pkg::HdrRunBit];
        left_d  = {1'b0, in_byte_q[tgarle_pkg::HdrRunBit-1:0]} + ByteW'(1);
        phase_d = PH_BLUE;
      end
    endcase

    // repeat count, clipped at the image end
    total_x = CmpW'(total_q);
    done_x  = CmpW'(done_s);
    want    = run_s ? CmpW'(left_s) : CmpW'(1);
    remain  = total_x - done_x;
    if (done_x >= total_x) begin
      rep = ByteW'(1);
      fin = 1'b1;
    end else if (want >= remain) begin
      rep = remain[ByteW-1:0];
      fin = 1'b1;
    end else begin
      rep = want[ByteW-1:0];
      fin = 1'b0;
    end

    if (emit) begin
      if (fin) begin
        done_d  = '0;
        left_d  = '0;
        phase_d = PH_HEADER;
      end else begin
        done_d = TotW'(done_x + CmpW'(rep));
        if (run_s || left_s <= ByteW'(1)) begin
          left_d  = '0;
          phase_d = PH_HEADER;
        end else begin
          left_d  = left_s - ByteW'(1);
          phase_d = PH_BLUE;
        end
      end
    end
  end

  // parser state and result register
  logic [ByteW-1:0] blue_oq, green_oq, red_oq, alpha_oq, rep_oq;
  logic             done_oq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      run_q     <= 1'b0;
      left_q    <= '0;
      blue_q    <= '0;
      green_q   <= '0;
      red_q     <= '0;
      done_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d;
        run_q   <= run_d;
        left_q  <= left_d;
        blue_q  <= blue_d;
        green_q <= green_d;
        red_q   <= red_d;
        done_q  <= done_d;
      end
      if (fire && emit) begin
        out_vld_q <= 1'b1;
      end else if (pix_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      blue_oq  <= blue_q;
      green_oq <= green_q;
      red_oq   <= red_d;
      alpha_oq <= alpha_sel;
      rep_oq   <= rep;
      done_oq  <= fin;
    end
  end

  assign pix_valid_o  = out_vld_q;
  assign blue_o       = blue_oq;
  assign green_o      = green_oq;
  assign red_o        = red_oq;
  assign alpha_o      = alpha_oq;
  assign repeat_res_o = rep_oq;
  assign image_done_o = done_oq;

endmodule

// ===== dv/tga_rle_pixel_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tga_rle_pixel_decoder_unit: byte driver, pixel monitor,
// and a cycle-free decode model of the run-length pixel stream.
// Depends on tgarle_pkg and the decoder RTL only.
module tga_rle_pixel_decoder_unit_tb;
  import tgarle_pkg::*;

  // one byte of the compressed stream
  typedef struct packed {
    logic             start;
    logic [ByteW-1:0] data;
  } stream_beat_t;

  // one decoded pixel result
  typedef struct packed {
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] red;
    logic [ByteW-1:0] alpha;
    logic [ByteW-1:0] reps;
    logic             done;
  } pixel_t;

  typedef enum logic [2:0] {AT_HEADER, AT_BLUE, AT_GREEN, AT_RED, AT_ALPHA} parse_e;

  // clock, reset, block ports
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic data_valid_i = 1'b0;
  logic data_ready_o;
  logic [ByteW-1:0] data_byte_i = '0;
  logic image_start_i = 1'b0;
  logic pix_valid_o;
  logic pix_ready_i = 1'b0;
  logic [ByteW-1:0] blue_o, green_o, red_o, alpha_o, repeat_res_o;
  logic image_done_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  // decode model state and its copy of the registers
  parse_e parse_at = AT_HEADER;
  bit run_pkt = 1'b0;
  logic [7:0] left_px = '0;
  logic [ByteW-1:0] hold_b = '0, hold_g = '0, hold_r = '0;
  int unsigned done_px = 0;
  bit alpha_on = 1'b0;
  logic [CfgW-1:0] width_cfg = WidthReset;
  logic [CfgW-1:0] height_cfg = HeightReset;

  // stream queues and bookkeeping
  stream_beat_t byte_q[$];
  pixel_t pixel_q[$];
  stream_beat_t drv_beat;
  pixel_t want_px;
  pixel_t model_px;
  int unsigned errors = 0;
  int unsigned bytes_in = 0;
  int unsigned pix_checked = 0;
  int unsigned images_done = 0;
  int unsigned keyed_cnt = 0;
  int unsigned clipped_cnt = 0;

  // generator settings and handshake pacing
  bit gen_alpha = 1'b0;
  int unsigned gen_total = 1;
  bit need_start = 1'b1;
  int unsigned src_pct = 30;
  int unsigned snk_pct = 30;
  int unsigned src_gap = 0;
  int unsigned snk_wait = 0;
  bit squeeze_req = 1'b0;
  bit squeeze_taken = 1'b0;
  int unsigned squeeze_left = 0;

  tga_rle_pixel_decoder_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .data_valid_i (data_valid_i),
    .data_ready_o (data_ready_o),
    .data_byte_i  (data_byte_i),
    .image_start_i(image_start_i),
    .pix_valid_o  (pix_valid_o),
    .pix_ready_i  (pix_ready_i),
    .blue_o       (blue_o),
    .green_o      (green_o),
    .red_o        (red_o),
    .alpha_o      (alpha_o),
    .repeat_res_o (repeat_res_o),
    .image_done_o (image_done_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= 30) $display("ERROR %0t ns: %s", $time, msg);
  endtask

  // width or height as the block uses it
  function automatic int unsigned dim_of(input logic [CfgW-1:0] v);
    if (v == '0) return 1;
    if (v > DefaultMaxDim) return DefaultMaxDim;
    return int'(v);
  endfunction

  // pixel completed: repeat count, clipping at image end, counter update
  function automatic pixel_t close_pixel(input logic [ByteW-1:0] a);
    pixel_t px;
    int unsigned total, want, reps;
    bit fin;
    total = dim_of(width_cfg) * dim_of(height_cfg);
    want = run_pkt ? int'(left_px) : 1;
    if (done_px >= total) begin
      reps = 1;
      fin = 1'b1;
    end else if (want >= total - done_px) begin
      reps = total - done_px;
      fin = 1'b1;
      if (want > reps) clipped_cnt++;
    end else begin
      reps = want;
      fin = 1'b0;
    end
    px.blue = hold_b;
    px.green = hold_g;
    px.red = hold_r;
    px.alpha = a;
    px.reps = reps[7:0];
    px.done = fin;
    if (fin) begin
      done_px = 0;
      left_px = '0;
      parse_at = AT_HEADER;
      images_done++;
    end else begin
      done_px += reps;
      if (run_pkt || left_px <= 8'd1) begin
        left_px = '0;
        parse_at = AT_HEADER;
      end else begin
        left_px--;
        parse_at = AT_BLUE;
      end
    end
    return px;
  endfunction

  // advance the parser by one byte; returns 1 when a pixel comes out
  function automatic bit decode_byte(input logic [ByteW-1:0] b, input logic start,
                                     output pixel_t px);
    bit got;
    got = 1'b0;
    px = '0;
    if (start) begin
      parse_at = AT_HEADER;
      run_pkt = 1'b0;
      left_px = '0;
      done_px = 0;
    end
    case (parse_at)
      AT_BLUE: begin
        hold_b = b;
        parse_at = AT_GREEN;
      end
      AT_GREEN: begin
        hold_g = b;
        parse_at = AT_RED;
      end
      AT_RED: begin
        hold_r = b;
        if (alpha_on) begin
          parse_at = AT_ALPHA;
        end else begin
          got = 1'b1;
          if (hold_r == KeyRed && hold_g == KeyGreen && hold_b == KeyBlue) begin
            keyed_cnt++;
            px = close_pixel(AlphaKeyed);
          end else begin
            px = close_pixel(AlphaOpaque);
          end
        end
      end
      AT_ALPHA: begin
        got = 1'b1;
        px = close_pixel(b);
      end
      default: begin
        run_pkt = b[HdrRunBit];
        left_px = {1'b0, b[6:0]} + 8'd1;
        parse_at = AT_BLUE;
      end
    endcase
    return got;
  endfunction

  // byte driver: after a beat, a random gap with a chance of src_pct percent
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_valid_i <= 1'b0;
      src_gap = 0;
    end else if (!data_valid_i || data_ready_o) begin
      if (src_gap != 0) begin
        src_gap--;
        data_valid_i <= 1'b0;
      end else if (byte_q.size() != 0) begin
        drv_beat = byte_q.pop_front();
        data_valid_i <= 1'b1;
        data_byte_i <= drv_beat.data;
        image_start_i <= drv_beat.start;
        src_gap = ($urandom_range(0, 99) < src_pct) ? $urandom_range(0, 19) : 0;
      end else begin
        data_valid_i <= 1'b0;
      end
    end
  end

  // pixel receiver: per-beat stall, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_ready_i <= 1'b0;
      snk_wait = 0;
      squeeze_left = 0;
    end else begin
      if (squeeze_req && !squeeze_taken) begin
        squeeze_taken = 1'b1;
        squeeze_left = 400;
      end
      if (squeeze_left != 0) begin
        squeeze_left--;
        pix_ready_i <= 1'b0;
      end else if (pix_valid_o && pix_ready_i) begin
        snk_wait = ($urandom_range(0, 99) < snk_pct) ? $urandom_range(0, 19) : 0;
        pix_ready_i <= (snk_wait == 0);
        if (snk_wait != 0) snk_wait--;
      end else if (snk_wait != 0) begin
        snk_wait--;
        pix_ready_i <= 1'b0;
      end else begin
        pix_ready_i <= 1'b1;
      end
    end
  end

  // model every accepted byte
  always @(posedge clk_i) begin
    if (rst_ni && data_valid_i && data_ready_o) begin
      bytes_in++;
      if (decode_byte(data_byte_i, image_start_i, model_px)) pixel_q.push_back(model_px);
    end
  end

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // compare each pixel beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && pix_valid_o && pix_ready_i) begin
      if (pixel_q.size() == 0) begin
        report("pixel beat with nothing predicted");
      end else begin
        want_px = pixel_q.pop_front();
        pix_checked++;
        check_field("blue", blue_o, want_px.blue);
        check_field("green", green_o, want_px.green);
        check_field("red", red_o, want_px.red);
        check_field("alpha", alpha_o, want_px.alpha);
        check_field("repeat_res", repeat_res_o, want_px.reps);
        check_field("image_done", {7'd0, image_done_o}, {7'd0, want_px.done});
      end
    end
  end

  task automatic put(input logic [7:0] b, input bit start);
    byte_q.push_back('{start: start, data: b});
  endtask

  // random pixel, biased toward the key color and colors one bit away from it
  task automatic put_pixel();
    logic [7:0] b, g, r;
    int unsigned pick, bit_at;
    pick = $urandom_range(0, 11);
    bit_at = $urandom_range(0, 7);
    b = 8'($urandom);
    g = 8'($urandom);
    r = 8'($urandom);
    if (pick < 3) begin
      b = KeyBlue;
      g = KeyGreen;
      r = KeyRed;
      if (pick == 2) begin
        case ($urandom_range(0, 2))
          0: b[bit_at] = ~b[bit_at];
          1: g[bit_at] = ~g[bit_at];
          default: r[bit_at] = ~r[bit_at];
        endcase
      end
    end
    put(b, 1'b0);
    put(g, 1'b0);
    put(r, 1'b0);
    if (gen_alpha) put(8'($urandom), 1'b0);
  endtask

  // well-formed image; large images stop once the phase budget is spent
  task automatic gen_image(input bit with_start, input int unsigned budget);
    int unsigned left, n;
    bit run, first;
    left = gen_total;
    first = with_start;
    need_start = 1'b0;
    while (left != 0 && (gen_total <= 256 || byte_q.size() < budget)) begin
      run = (left > 256) ? ($urandom_range(0, 7) != 0) : 1'($urandom_range(0, 1));
      if (left > 256) n = $urandom_range(96, 128);
      else if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 128);
      else n = $urandom_range(1, (left < 12) ? left : 12);
      put({run, 7'(n - 1)}, first);
      first = 1'b0;
      // an oversized raw packet is clipped, so only the pixels it still needs follow
      if (run) put_pixel();
      else repeat ((n < left) ? n : left) put_pixel();
      left = (n >= left) ? 0 : left - n;
    end
  endtask

  // mix of images, noise bytes and truncated packets
  task automatic fill_phase(input int unsigned budget);
    int unsigned pick, n;
    while (byte_q.size() < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 76) begin
        gen_image(need_start || ($urandom_range(0, 1) == 1), budget);
      end else if (pick < 88) begin
        n = $urandom_range(1, 10);
        repeat (n) put(8'($urandom), $urandom_range(0, 7) == 0);
        need_start = 1'b1;
      end else begin
        put(8'($urandom), 1'b0);
        repeat ($urandom_range(0, gen_alpha ? 3 : 2)) put(8'($urandom), 1'b0);
        need_start = 1'b1;
      end
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ALPHA_IN_STREAM: alpha_on = val[0];
      CFG_IMAGE_WIDTH: width_cfg = val;
      default: height_cfg = val;
    endcase
  endtask

  // all three registers back to back; upper bits of the mode write are junk
  task automatic set_config(input bit a, input logic [CfgW-1:0] w,
                            input logic [CfgW-1:0] h);
    write_reg(CFG_ALPHA_IN_STREAM, {12'($urandom), a});
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    cfg_valid_i <= 1'b0;
    gen_alpha = a;
    gen_total = dim_of(w) * dim_of(h);
  endtask

  // wait until every byte is in and every pixel is out, then a few quiet cycles
  task automatic drain();
    int unsigned quiet, spent;
    quiet = 0;
    spent = 0;
    while (quiet < 8 && spent < 50000) begin
      @(posedge clk_i);
      spent++;
      if (byte_q.size() == 0 && !data_valid_i && pixel_q.size() == 0) quiet++;
      else quiet = 0;
    end
    if (quiet < 8) begin
      report($sformatf("%0d predicted pixels never arrived", pixel_q.size()));
      pixel_q.delete();
    end
  endtask

  initial begin
    bit cfg_a;
    logic [CfgW-1:0] cfg_w, cfg_h;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 2x2 image: raw keyed pixel, a full-size run clipped at the end,
    // then a full-size raw packet into the next image, of which only two pixels are sent
    set_config(1'b0, 13'd2, 13'd2);
    @(negedge clk_i);
    put(8'h00, 1'b1);
    put(KeyBlue, 1'b0); put(KeyGreen, 1'b0); put(KeyRed, 1'b0);
    put(8'hff, 1'b0);
    put(8'h00, 1'b0); put(8'h00, 1'b0); put(8'h00, 1'b0);
    put(8'h7f, 1'b0);
    put(8'h80, 1'b0); put(8'h7f, 1'b0); put(8'h01, 1'b0);
    put(8'h01, 1'b0); put(8'h02, 1'b0); put(8'h03, 1'b0);
    drain();

    // image shrinks below the pixels already counted
    set_config(1'b0, 13'd4, 13'd4);
    @(negedge clk_i);
    put(8'h89, 1'b1);
    put(8'h10, 1'b0); put(8'h20, 1'b0); put(8'h30, 1'b0);
    drain();
    set_config(1'b0, 13'd2, 13'd2);
    @(negedge clk_i);
    put(8'h00, 1'b0);
    put(8'h44, 1'b0); put(8'h55, 1'b0); put(8'h66, 1'b0);
    drain();

    // zero sizes act as 1x1; alpha taken from the stream
    set_config(1'b1, 13'd0, 13'd0);
    @(negedge clk_i);
    put(8'h80, 1'b1);
    put(8'h12, 1'b0); put(8'h34, 1'b0); put(8'h56, 1'b0); put(8'hab, 1'b0);
    drain();

    // random phases: size extremes first, then small random sizes
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin cfg_a = 1'b0; cfg_w = 13'd3;    cfg_h = 13'd2;    end
        1: begin cfg_a = 1'b1; cfg_w = 13'd1;    cfg_h = 13'd1;    end
        2: begin cfg_a = 1'b0; cfg_w = 13'd4096; cfg_h = 13'd1;    end
        3: begin cfg_a = 1'b1; cfg_w = 13'd1;    cfg_h = 13'd4096; end
        4: begin cfg_a = 1'b0; cfg_w = 13'd8191; cfg_h = 13'd8191; end
        5: begin cfg_a = 1'b1; cfg_w = 13'd0;    cfg_h = 13'd5;    end
        6: begin cfg_a = 1'b0; cfg_w = 13'd7;    cfg_h = 13'd5;    end
        7: begin cfg_a = 1'b1; cfg_w = 13'd5000; cfg_h = 13'd0;    end
        default: begin
          cfg_a = 1'($urandom_range(0, 1));
          cfg_w = 13'($urandom_range(1, 12));
          cfg_h = 13'($urandom_range(1, 12));
        end
      endcase
      set_config(cfg_a, cfg_w, cfg_h);
      @(negedge clk_i);
      src_pct <= (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 35 : 100);
      snk_pct <= (ph % 4 == 1) ? 0 : ((ph % 4 == 2) ? 100 : 30);
      // output blocked for a long stretch while bytes keep coming
      if (ph == 5) squeeze_req <= 1'b1;
      fill_phase(100);
      drain();
    end

    $display("Decoded %0d bytes into %0d checked pixel beats, %0d images completed.",
             bytes_in, pix_checked, images_done);
    $display("Keyed pixels: %0d, clipped packets: %0d; both depths, clamped sizes, long stall.",
             keyed_cnt, clipped_cnt);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #4_000_000;
    $display("Run limit reached with %0d bytes still queued.", byte_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tgarle_pkg.sv
rtl/core/tga_rle_pixel_decoder_unit.sv
dv/tga_rle_pixel_decoder_unit_tb.sv
